@@ design/gpr_pkg.sv @@
// Package for the GPIO port register block: request and result types,
// register select codes, reset values and the pin count.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package gpr_pkg;

	localparam int unsigned PIN_COUNT = 16;
	localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);

	localparam logic [31:0] CFG_RESET = 32'h4444_4444;

	// Field codes inside one 4-bit pin nibble.
	localparam logic [1:0] MODE_INPUT = 2'b00;
	localparam logic [1:0] CNF_PULL   = 2'b10;

	typedef enum logic {
		REQ_READ  = 1'b0,
		REQ_WRITE = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		SEL_CFG_LOW  = 3'd0,
		SEL_CFG_HIGH = 3'd1,
		SEL_IN_DATA  = 3'd2,
		SEL_OUT_DATA = 3'd3,
		SEL_BIT_SR   = 3'd4
	} reg_sel_t;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  reg_select;
		logic [31:0] write_data;
		logic [15:0] pad_levels;
	} req_t;

	typedef struct packed {
		logic [31:0] cfg_low;
		logic [31:0] cfg_high;
		logic [15:0] out_data;
	} port_state_t;

	typedef struct packed {
		logic [15:0] drive_enable;
		logic [15:0] drive_value;
		logic [15:0] pull_enable;
		logic [15:0] pull_up;
	} pin_ctrl_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_access;
		pin_ctrl_t   pins;
	} result_t;

endpackage

`default_nettype wire

@@ design/gpr_regfile.sv @@
// Port registers of the GPIO block: two configuration words and the output
// data word, with the read multiplexer and the write and set/reset merge.
// Depends on gpr_pkg.
`default_nettype none

module gpr_regfile (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                commit,
	input  wire gpr_pkg::req_t       req,
	output      logic [31:0]         read_data,
	output      logic                bad_access,
	output      gpr_pkg::port_state_t state_next
);
	import gpr_pkg::*;

	logic [31:0] cfg_low_q;
	logic [31:0] cfg_high_q;
	logic [15:0] out_data_q;

	always_comb begin
		state_next.cfg_low  = cfg_low_q;
		state_next.cfg_high = cfg_high_q;
		state_next.out_data = out_data_q;
		read_data           = '0;
		bad_access          = 1'b0;
		if (req.req_type == REQ_READ) begin
			case (req.reg_select)
				SEL_CFG_LOW:  read_data = cfg_low_q;
				SEL_CFG_HIGH: read_data = cfg_high_q;
				SEL_IN_DATA:  read_data = {16'd0, req.pad_levels & PIN_MASK};
				SEL_OUT_DATA: read_data = {16'd0, out_data_q};
				SEL_BIT_SR:   read_data = '0;
				default:      bad_access = 1'b1;
			endcase
		end else begin
			case (req.reg_select)
				SEL_CFG_LOW:  state_next.cfg_low = req.write_data;
				SEL_CFG_HIGH: state_next.cfg_high = req.write_data;
				SEL_IN_DATA:  bad_access = 1'b1;
				SEL_OUT_DATA: state_next.out_data = req.write_data[15:0] & PIN_MASK;
				SEL_BIT_SR: begin
					// Set bits are merged after the clears, so set wins.
					state_next.out_data = ((out_data_q & ~req.write_data[31:16])
						| req.write_data[15:0]) & PIN_MASK;
				end
				default:      bad_access = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_low_q  <= CFG_RESET;
			cfg_high_q <= CFG_RESET;
			out_data_q <= '0;
		end else if (commit) begin
			cfg_low_q  <= state_next.cfg_low;
			cfg_high_q <= state_next.cfg_high;
			out_data_q <= state_next.out_data;
		end
	end

endmodule

`default_nettype wire

@@ design/gpr_pin_decode.sv @@
// Per-pin decode of mode and config nibbles into drive and pull controls.
// Purely combinational; depends on gpr_pkg.
`default_nettype none

module gpr_pin_decode (
	input  wire gpr_pkg::port_state_t state,
	output      gpr_pkg::pin_ctrl_t   pins
);
	import gpr_pkg::*;

	logic [63:0] cfg_all;

	assign cfg_all = {state.cfg_high, state.cfg_low};

	always_comb begin
		pins = '0;
		for (int i = 0; i < 16; i++) begin
			if (PIN_MASK[i]) begin
				if (cfg_all[4*i +: 2] != MODE_INPUT) begin
					// Open-drain pins only pull low.
					if (cfg_all[4*i + 2]) begin
						pins.drive_enable[i] = ~state.out_data[i];
					end else begin
						pins.drive_enable[i] = 1'b1;
						pins.drive_value[i]  = state.out_data[i];
					end
				end else if (cfg_all[4*i + 2 +: 2] == CNF_PULL) begin
					pins.pull_enable[i] = 1'b1;
					pins.pull_up[i]     = state.out_data[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ design/gpio_port_register_block.sv @@
// Top level of the GPIO port register block: input register, register file,
// pin decode and result register. Depends on gpr_pkg, gpr_regfile and
// gpr_pin_decode.
//
// Each request is a read or write of one port register. It is registered on
// acceptance and executed once the result register can take its result,
// which is then registered there. One request is taken every cycle while the
// result path is not stalled; the single pass of decode and bit merging between
// the input register and the result register sets that rate. Ready drops only
// while a result is held by the consumer.
`default_nettype none

module gpio_port_register_block (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	input  wire logic [47:0]  s_tdata,  // write_data[31:0], pad_levels[47:32]
	input  wire logic [3:0]   s_tuser,  // req_type[0], reg_select[3:1]
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	output      logic [95:0]  m_tdata,  // read_data, drive_enable, drive_value,
	                                    // pull_enable, pull_up
	output      logic [0:0]   m_tuser   // bad_access[0]
);
	import gpr_pkg::*;

	req_t        req_s1;
	logic        vld_s1;
	result_t     res_s2;
	logic        vld_s2;
	logic        advance;
	logic        commit;
	logic [31:0] rd_data;
	logic        rd_bad;
	port_state_t state_next;
	pin_ctrl_t   pins;

	assign advance  = !vld_s2 || m_tready;
	assign commit   = vld_s1 && advance;
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.req_type   <= s_tuser[0];
			req_s1.reg_select <= s_tuser[3:1];
			req_s1.write_data <= s_tdata[31:0];
			req_s1.pad_levels <= s_tdata[47:32];
		end
	end

	gpr_regfile u_regfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (commit),
		.req        (req_s1),
		.read_data  (rd_data),
		.bad_access (rd_bad),
		.state_next (state_next)
	);

	gpr_pin_decode u_pin_decode (
		.state (state_next),
		.pins  (pins)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_s2.read_data  <= rd_data;
			res_s2.bad_access <= rd_bad;
			res_s2.pins       <= pins;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.bad_access;
	assign m_tdata  = {res_s2.pins.pull_up, res_s2.pins.pull_enable,
		res_s2.pins.drive_value, res_s2.pins.drive_enable, res_s2.read_data};

`ifndef ASSERT_OFF
	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
		else $error("bad request returned nonzero read data");

	a_drive_value_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:48] & ~m_tdata[47:32]) == 16'd0)
		else $error("drive value set on an undriven pin");

	a_pull_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[79:64] & m_tdata[47:32]) == 16'd0
			&& (m_tdata[95:80] & ~m_tdata[79:64]) == 16'd0)
		else $error("pull control conflicts with drive control");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_s1 && m_tvalid && !m_tready)
		else $error("input stalled while the result path was free");

	a_result_follows_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid)
		else $error("executed request produced no result");
`endif

endmodule

`default_nettype wire
